@@ sv/mtwq_pkg.sv @@
// ----------------------------------------------------------------------------
// mtwq_pkg
// Shared sizes, codes and types for the mutex table with wait queues.
// ----------------------------------------------------------------------------
package mtwq_pkg;

    localparam int NUM_MUTEXES = 32;
    localparam int NUM_TASKS   = 64;

    localparam int FUNC_W    = 2;
    localparam int MUTEX_W   = 6;
    localparam int TASK_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int CREATED_W = 5;
    localparam int COUNT_W   = 6;

    localparam int MUTEX_AW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int TASK_AW  = $clog2(NUM_TASKS);

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef enum logic [FUNC_W-1:0] {
        F_CREATE = 2'd0,
        F_LOCK   = 2'd1,
        F_UNLOCK = 2'd2,
        F_RSVD   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_DEADLOCK = 3'd3,
        ST_NOTOWNER = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_CREATE,
        K_LOCK,
        K_UNLOCK,
        K_BAD
    } t_kind;

    typedef enum logic [2:0] {
        A_NONE,
        A_CREATE,
        A_ACQUIRE,
        A_ENQUEUE,
        A_RELEASE,
        A_HANDOFF
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_UPD1,
        S_UPD2,
        S_UPD3,
        S_FIN
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [MUTEX_W-1:0]  mutex_id;
        logic [TASK_W-1:0]   task_id;
        logic                task_ok;
    } t_cmd;

    function automatic logic task_in_range(input logic [TASK_W-1:0] v);
        return {1'b0, v} < (TASK_W+1)'(NUM_TASKS);
    endfunction

    function automatic logic mutex_in_range(input logic [MUTEX_W-1:0] v);
        return {1'b0, v} < (MUTEX_W+1)'(NUM_MUTEXES);
    endfunction

endpackage

@@ sv/mtwq_front.sv @@
// ----------------------------------------------------------------------------
// mtwq_front
// Takes request transfers and sorts them into create, lock, unlock or
// invalid before they enter the command queue.
// ----------------------------------------------------------------------------
module mtwq_front
    import mtwq_pkg::*;
(
    input  logic               i_valid,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [MUTEX_W-1:0] i_mutex_id,
    input  logic [TASK_W-1:0]  i_task_id,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic task_ok;
    logic mutex_ok;

    assign task_ok  = task_in_range(i_task_id);
    assign mutex_ok = mutex_in_range(i_mutex_id);
    assign o_push   = i_valid && !i_full;

    always_comb begin
        o_cmd.mutex_id = i_mutex_id;
        o_cmd.task_id  = i_task_id;
        o_cmd.task_ok  = task_ok;
        unique case (t_func'(i_func))
            F_CREATE: o_cmd.kind = K_CREATE;
            F_LOCK:   o_cmd.kind = (task_ok && mutex_ok) ? K_LOCK : K_BAD;
            F_UNLOCK: o_cmd.kind = (task_ok && mutex_ok) ? K_UNLOCK : K_BAD;
            default:  o_cmd.kind = K_BAD;
        endcase
    end

endmodule

@@ sv/mtwq_queue.sv @@
// ----------------------------------------------------------------------------
// mtwq_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mtwq_queue
    import mtwq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/mtwq_back.sv @@
// ----------------------------------------------------------------------------
// mtwq_back
// Sequencer that carries out one command over several steps against the
// mutex tables, the wait links and the hold counts, then loads the result.
// ----------------------------------------------------------------------------
module mtwq_back
    import mtwq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [CREATED_W-1:0] o_created_id,
    output logic                 o_caller_blocked,
    output logic                 o_wake_valid,
    output logic [TASK_W-1:0]    o_wake_task,
    output logic [COUNT_W-1:0]   o_caller_hold_count
);

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_dec(input logic [COUNT_W-1:0] v);
        return (v == '0) ? v : v - COUNT_W'(1);
    endfunction

    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_act   r_act, n_act;
    t_status r_status, n_status;

    logic [MUTEX_AW-1:0] r_new_idx;
    logic [TASK_W-1:0]   r_h;
    logic [TASK_W-1:0]   r_tail;
    logic                r_qne;
    logic [COUNT_W-1:0]  r_cnt;

    logic [NUM_MUTEXES-1:0] r_alloc;
    logic [NUM_MUTEXES-1:0] r_locked;
    logic [NUM_MUTEXES-1:0] r_qne_tab;
    logic [TASK_W-1:0]      r_holder   [NUM_MUTEXES];
    logic [TASK_W-1:0]      r_head_tab [NUM_MUTEXES];
    logic [TASK_W-1:0]      r_tail_tab [NUM_MUTEXES];

    logic [COUNT_W-1:0]   r_hc_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_hc_vld;
    logic [COUNT_W-1:0]   r_hc_rd;
    logic                 r_hc_rd_vld;
    logic [TASK_W-1:0]    r_nw_mem [NUM_TASKS];
    logic [TASK_W-1:0]    r_nw_rd;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [CREATED_W-1:0] r_out_created;
    logic                 r_out_blocked;
    logic                 r_out_wake_valid;
    logic [TASK_W-1:0]    r_out_wake_task;
    logic [COUNT_W-1:0]   r_out_count;

    logic [MUTEX_AW-1:0] m_idx;
    logic [TASK_W-1:0]   t_id;
    logic [TASK_AW-1:0]  t_idx;
    logic [TASK_AW-1:0]  h_idx;
    logic                h_ok;
    logic                tail_ok;
    logic                h_last;
    logic                free_found;
    logic [MUTEX_AW-1:0] free_idx;
    logic [COUNT_W-1:0]  hc_q;
    logic [COUNT_W-1:0]  inc_q;
    logic [COUNT_W-1:0]  dec_q;

    logic                hc_re;
    logic [TASK_AW-1:0]  hc_raddr;
    logic                hc_we;
    logic [TASK_AW-1:0]  hc_waddr;
    logic [COUNT_W-1:0]  hc_wdata;
    logic                nw_re;
    logic                nw_we;
    logic [TASK_AW-1:0]  nw_waddr;
    logic                out_load;

    assign m_idx   = r_cmd.mutex_id[MUTEX_AW-1:0];
    assign t_id    = r_cmd.task_id;
    assign t_idx   = r_cmd.task_id[TASK_AW-1:0];
    assign h_idx   = r_h[TASK_AW-1:0];
    assign h_ok    = task_in_range(r_h);
    assign tail_ok = task_in_range(r_tail);
    assign h_last  = (r_h == r_tail) || !h_ok;
    assign hc_q    = r_hc_rd_vld ? r_hc_rd : '0;
    assign inc_q   = sat_inc(hc_q);
    assign dec_q   = sat_dec(hc_q);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_MUTEXES - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_found = 1'b1;
                free_idx   = MUTEX_AW'(i);
            end
        end
    end

    always_comb begin
        n_act    = A_NONE;
        n_status = ST_OK;
        unique case (r_cmd.kind)
            K_CREATE: begin
                if (free_found) begin
                    n_act = A_CREATE;
                end else begin
                    n_status = ST_NOMEM;
                end
            end
            K_LOCK: begin
                priority if (!r_alloc[m_idx]) begin
                    n_status = ST_INVALID;
                end else if (r_locked[m_idx] && r_holder[m_idx] == t_id) begin
                    n_status = ST_DEADLOCK;
                end else if (!r_locked[m_idx]) begin
                    n_act = A_ACQUIRE;
                end else begin
                    n_act = A_ENQUEUE;
                end
            end
            K_UNLOCK: begin
                priority if (!r_alloc[m_idx] || !r_locked[m_idx]) begin
                    n_status = ST_INVALID;
                end else if (r_holder[m_idx] != t_id) begin
                    n_status = ST_NOTOWNER;
                end else if (r_qne_tab[m_idx]) begin
                    n_act = A_HANDOFF;
                end else begin
                    n_act = A_RELEASE;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_cmd_valid) n_state = S_DECIDE;
            S_DECIDE: n_state = S_UPD1;
            S_UPD1:   n_state = S_UPD2;
            S_UPD2:   n_state = S_UPD3;
            S_UPD3:   n_state = S_FIN;
            S_FIN:    if (!r_out_valid || !i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        hc_re    = 1'b0;
        hc_raddr = t_idx;
        hc_we    = 1'b0;
        hc_waddr = t_idx;
        hc_wdata = inc_q;
        nw_re    = 1'b0;
        nw_we    = 1'b0;
        nw_waddr = t_idx;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = i_cmd_valid;
            end
            S_DECIDE: begin
                hc_re = 1'b1;
                nw_re = 1'b1;
            end
            S_UPD1: begin
                unique case (r_act)
                    A_ACQUIRE: begin
                        hc_we = 1'b1;
                    end
                    A_RELEASE, A_HANDOFF: begin
                        hc_we    = 1'b1;
                        hc_wdata = dec_q;
                    end
                    A_ENQUEUE: begin
                        nw_we = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_UPD2: begin
                if (r_act == A_ENQUEUE && r_qne && tail_ok) begin
                    nw_we    = 1'b1;
                    nw_waddr = r_tail[TASK_AW-1:0];
                end
                if (r_act == A_HANDOFF) begin
                    hc_re    = 1'b1;
                    hc_raddr = h_idx;
                end
            end
            S_UPD3: begin
                if (r_act == A_HANDOFF && h_ok) begin
                    hc_we    = 1'b1;
                    hc_waddr = h_idx;
                end
            end
            S_FIN: begin
                out_load = !r_out_valid || !i_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= A_NONE;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE) begin
                r_act <= n_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_DECIDE) begin
            r_status  <= n_status;
            r_new_idx <= free_idx;
            r_h       <= r_head_tab[m_idx];
            r_tail    <= r_tail_tab[m_idx];
            r_qne     <= r_qne_tab[m_idx];
        end
        if (r_state == S_UPD1) begin
            unique case (r_act)
                A_ACQUIRE:            r_cnt <= inc_q;
                A_RELEASE, A_HANDOFF: r_cnt <= dec_q;
                default:              r_cnt <= hc_q;
            endcase
        end
        if (r_state == S_UPD3 && r_act == A_HANDOFF && h_ok && r_h == t_id) begin
            r_cnt <= inc_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc   <= '0;
            r_locked  <= '0;
            r_qne_tab <= '0;
            for (int i = 0; i < NUM_MUTEXES; i++) begin
                r_holder[i] <= '0;
            end
        end else if (r_state == S_UPD1) begin
            unique case (r_act)
                A_CREATE: begin
                    r_alloc[r_new_idx] <= 1'b1;
                end
                A_ACQUIRE: begin
                    r_locked[m_idx] <= 1'b1;
                    r_holder[m_idx] <= t_id;
                end
                A_ENQUEUE: begin
                    r_qne_tab[m_idx] <= 1'b1;
                end
                A_RELEASE: begin
                    r_locked[m_idx] <= 1'b0;
                    r_holder[m_idx] <= '0;
                end
                A_HANDOFF: begin
                    r_holder[m_idx] <= r_h;
                    if (h_last) begin
                        r_qne_tab[m_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD1) begin
            if (r_act == A_ENQUEUE) begin
                r_tail_tab[m_idx] <= t_id;
                if (!r_qne) begin
                    r_head_tab[m_idx] <= t_id;
                end
            end
            if (r_act == A_HANDOFF && !h_last) begin
                r_head_tab[m_idx] <= r_nw_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hc_we) begin
            r_hc_mem[hc_waddr] <= hc_wdata;
        end
        if (hc_re) begin
            r_hc_rd <= r_hc_mem[hc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc_vld    <= '0;
            r_hc_rd_vld <= 1'b0;
        end else begin
            if (hc_we) begin
                r_hc_vld[hc_waddr] <= 1'b1;
            end
            if (hc_re) begin
                r_hc_rd_vld <= r_hc_vld[hc_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (nw_we) begin
            r_nw_mem[nw_waddr] <= t_id;
        end
        if (nw_re) begin
            r_nw_rd <= r_nw_mem[r_head_tab[m_idx][TASK_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status     <= r_status;
            r_out_created    <= (r_act == A_CREATE) ? CREATED_W'(r_new_idx) : '0;
            r_out_blocked    <= (r_act == A_ENQUEUE);
            r_out_wake_valid <= (r_act == A_HANDOFF);
            r_out_wake_task  <= (r_act == A_HANDOFF) ? r_h : '0;
            r_out_count      <= r_cmd.task_ok ? r_cnt : '0;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_created_id        = r_out_created;
    assign o_caller_blocked    = r_out_blocked;
    assign o_wake_valid        = r_out_wake_valid;
    assign o_wake_task         = r_out_wake_task;
    assign o_caller_hold_count = r_out_count;

endmodule

@@ sv/mutex_table_with_wait_queues.sv @@
// ----------------------------------------------------------------------------
// mutex_table_with_wait_queues
// Mutex manager over a fixed table with a FIFO wait queue per mutex.
// The back end sequencer steps each request through its DECIDE, UPD1, UPD2,
// UPD3 and FIN states and pops the next request only after FIN. Two requests
// can wait in the command queue. Reset clears the alloc, lock, wait flag and
// holder tables and the hold count valid bits; head, tail and links are kept.
// ----------------------------------------------------------------------------
module mutex_table_with_wait_queues
    import mtwq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [MUTEX_W-1:0]   i_mutex_id,
    input  logic [TASK_W-1:0]    i_task_id,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [CREATED_W-1:0] o_created_id,
    output logic                 o_caller_blocked,
    output logic                 o_wake_valid,
    output logic [TASK_W-1:0]    o_wake_task,
    output logic [COUNT_W-1:0]   o_caller_hold_count
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    assign o_stall = queue_full;

    mtwq_front u_front (
        .i_valid    (i_valid),
        .i_func     (i_func),
        .i_mutex_id (i_mutex_id),
        .i_task_id  (i_task_id),
        .i_full     (queue_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    mtwq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    mtwq_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (!queue_empty),
        .i_cmd               (queue_cmd),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_created_id        (o_created_id),
        .o_caller_blocked    (o_caller_blocked),
        .o_wake_valid        (o_wake_valid),
        .o_wake_task         (o_wake_task),
        .o_caller_hold_count (o_caller_hold_count)
    );

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wake_valid |-> o_status == ST_OK && !o_caller_blocked)
        else $error("wake-up reported on a failed or blocking request");

    a_blocked_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_caller_blocked |-> o_status == ST_OK && o_created_id == '0)
        else $error("blocked caller reported on a failed request");

    a_created_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_created_id != '0 |-> o_status == ST_OK && !o_wake_valid)
        else $error("created index reported on a failed request");

endmodule
